>>> rtl/core/uer_pkg.sv
// shared types, widths and reset constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
`default_nettype none

package uer_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int TRIG_W    = 16;
    localparam int HOLD_W    = 24;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 24;
    localparam int EXT_W     = 32;
    localparam int FRAC_SH   = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_FIELD_W = 1 + 1 + OUT_W + OUT_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [EXT_W-1:0] OUT_MAX = EXT_W'(32'h00FF_FFFF);

    localparam logic [TRIG_W-1:0]  TRIG_RST  = TRIG_W'(160);
    localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(3200000);
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(17983);

    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_MEASURE = 2'd2,
        PH_HOLD    = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_HOLDOFF_TICKS = 2'd1,
        REG_SCALE_FACTOR  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [HOLD_W-1:0]  holdoff_ticks;
        logic [SCALE_W-1:0] scale_factor;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/uer_front.sv
// front end: per-tick phase sequencer, trigger timing and echo width counter
// depends on uer_pkg
`default_nettype none

module uer_front
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic                  echo_level,
    input  wire cfg_t                  cfg,
    output logic                       item_trig,
    output logic                       item_valid,
    output logic [COUNT_BITS-1:0]      item_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  echo_prev_reg;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cnt_at_max;
    logic                  trig_done;
    logic                  hold_done;

    always_comb begin
        cnt_inc    = (count_reg == CNT_MAX) ? count_reg : count_reg + COUNT_BITS'(1);
        cnt_at_max = (cnt_inc == CNT_MAX);
        trig_done  = (EXT_W'(cnt_inc) >= EXT_W'(cfg.trigger_ticks)) || cnt_at_max;
        hold_done  = (EXT_W'(cnt_inc) >= EXT_W'(cfg.holdoff_ticks)) || cnt_at_max;
    end

    // next state and counter
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            PH_TRIGGER: begin
                count_next = cnt_inc;
                if (trig_done) begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo_level && !echo_prev_reg) begin
                    phase_next = PH_MEASURE;
                    count_next = COUNT_BITS'(1);
                end
            end
            PH_MEASURE: begin
                if (echo_level) begin
                    count_next = cnt_inc;
                end else begin
                    phase_next = PH_HOLD;
                    count_next = '0;
                end
            end
            PH_HOLD: begin
                count_next = cnt_inc;
                if (hold_done) begin
                    phase_next = PH_TRIGGER;
                    count_next = '0;
                end
            end
            default: begin
                phase_next = PH_TRIGGER;
                count_next = '0;
            end
        endcase
    end

    // per-tick outputs
    always_comb begin
        item_trig  = (phase_reg == PH_TRIGGER);
        item_valid = (phase_reg == PH_MEASURE) && !echo_level;
        item_count = item_valid ? count_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TRIGGER;
            count_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            echo_prev_reg <= echo_level;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/uer_queue.sv
// small register fifo between the front end and the result stage
// depends on uer_pkg for the default width and depth
`default_nettype none

module uer_queue
    import uer_pkg::*;
#(
    parameter int WIDTH = COUNT_BITS_DEF + 2,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    // depth must be a power of two, at least 2; the block itself does not check it
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = PTR_W + 1;

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    always_comb begin
        full     = (fill_reg == FILL_W'(DEPTH));
        empty    = (fill_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = entry_reg[rd_ptr_reg];
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/uer_back.sv
// result stage: distance scaling, clipping and the output register
// depends on uer_pkg
`default_nettype none

module uer_back
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  wire logic                  q_trig,
    input  wire logic                  q_valid,
    input  wire logic [COUNT_BITS-1:0] q_count,
    output logic                       q_pop,
    input  wire logic [SCALE_W-1:0]    scale_factor,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam int PROD_W = EXT_W + SCALE_W;
    localparam int PAD_W  = M_TDATA_W - M_FIELD_W;

    logic [EXT_W-1:0]     c_ext;
    logic [PROD_W-1:0]    prod;
    logic [EXT_W-1:0]     dist_full;
    logic [OUT_W-1:0]     dist_clip;
    logic [OUT_W-1:0]     width;
    logic                 sat;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    always_comb begin
        c_ext     = EXT_W'(q_count);
        prod      = PROD_W'(c_ext) * PROD_W'(scale_factor);
        dist_full = prod[FRAC_SH +: EXT_W];
        dist_clip = (dist_full > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : dist_full[OUT_W-1:0];
        width     = (c_ext > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : c_ext[OUT_W-1:0];
        // zeroed counts from non-result ticks fall out as all-zero fields
        sat       = q_valid && ((q_count == CNT_MAX) || (c_ext > OUT_MAX));
        out_data_next = {{PAD_W{1'b0}}, sat, dist_clip, width, q_valid, q_trig};
        q_pop     = !q_empty && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/ultrasonic_echo_ranger_top.sv
// data path: an accepted tick is queued, then moved into the output register that drives m_tdata
// throughput: one tick per clock while the queue has room, set by the front-end phase sequencer;
//   a two-entry queue and the output register let either side stall on its own
// reset: synchronous active-low aresetn returns to the trigger phase with the counter at zero,
//   empties the queue and output register, and loads the register defaults
// top level: configuration registers, front end, queue and result stage
// depends on uer_pkg, uer_front, uer_queue, uer_back
`default_nettype none

module ultrasonic_echo_ranger_top
    import uer_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // fields from bit 0: echo_level
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // fields from bit 0: trigger_level, result_valid, pulse_ticks, distance_q8, saturated
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int ITEM_W = COUNT_BITS + 2;

    cfg_t                  cfg_reg;
    logic                  accept;
    logic                  q_full, q_empty, q_pop;
    logic                  f_trig, f_valid;
    logic [COUNT_BITS-1:0] f_count;
    logic [ITEM_W-1:0]     q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks <= TRIG_RST;
            cfg_reg.holdoff_ticks <= HOLD_RST;
            cfg_reg.scale_factor  <= SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_wdata[TRIG_W-1:0];
                REG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks <= cfg_wdata[HOLD_W-1:0];
                REG_SCALE_FACTOR:  cfg_reg.scale_factor  <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    uer_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .item_trig  (f_trig),
        .item_valid (f_valid),
        .item_count (f_count)
    );

    assign q_in = {f_count, f_valid, f_trig};

    uer_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    uer_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_trig       (q_out[0]),
        .q_valid      (q_out[1]),
        .q_count      (q_out[ITEM_W-1:2]),
        .q_pop        (q_pop),
        .scale_factor (cfg_reg.scale_factor),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/uer_checker.sv
// port-level checks on the result stream of the echo ranger, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger_top
`default_nettype none

module uer_checker
    import uer_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    localparam int SAT_BIT = 2 + 2 * OUT_W;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a measurement never ends during a trigger tick
    a_no_trig_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("result during trigger pulse");

    // width, distance and flag are zero on ticks that carry no measurement
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> (m_tdata[M_TDATA_W-1:2] == '0))
        else $error("measurement fields set without a result");

    // the saturation flag comes only with a nonzero width
    a_sat_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SAT_BIT] |-> (m_tdata[OUT_W+1:2] != '0))
        else $error("saturation flagged with zero width");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
